// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Short forms for clocked concurrent assertions used across the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every rising edge out of reset
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked at every rising edge out of reset
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bsos_pkg.sv =====
// ---------------------------------------------------------------------------
// bsos_pkg
// Shared types and constants for the board square occupancy block
// ---------------------------------------------------------------------------
package bsos_pkg;

  localparam int SQ_IDX_W   = 6;
  localparam int MEAS_W     = 12;
  localparam int NEED_W     = 8;
  localparam int KIND_W     = 2;
  localparam int BOARD_W    = 64;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 136;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 12;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_CALIBRATED = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_NEED       = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_STRONG     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MODERATE   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_CLEAR      = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_TEXTURE    = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_FLAT       = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_DARK       = 3'd7;

  // reset values of the registers
  localparam logic [NEED_W-1:0] RST_NEED     = 8'd5;
  localparam logic [MEAS_W-1:0] RST_STRONG   = 12'd108;
  localparam logic [MEAS_W-1:0] RST_MODERATE = 12'd54;
  localparam logic [MEAS_W-1:0] RST_CLEAR    = 12'd36;
  localparam logic [MEAS_W-1:0] RST_TEXTURE  = 12'd192;
  localparam logic [MEAS_W-1:0] RST_FLAT     = 12'd128;
  localparam logic [MEAS_W-1:0] RST_DARK     = 12'd1600;

  // event kinds
  localparam logic [KIND_W-1:0] EVT_MOVE     = 2'd0;
  localparam logic [KIND_W-1:0] EVT_STABLE   = 2'd1;
  localparam logic [KIND_W-1:0] EVT_UNSTABLE = 2'd2;

  typedef struct packed {
    logic              calibrated;
    logic [MEAS_W-1:0] strong_edge_limit;
    logic [MEAS_W-1:0] moderate_edge_limit;
    logic [MEAS_W-1:0] clear_edge_limit;
    logic [MEAS_W-1:0] texture_dev_limit;
    logic [MEAS_W-1:0] flat_dev_limit;
    logic [MEAS_W-1:0] dark_mean_limit;
  } thr_cfg_t;

  typedef struct packed {
    logic [MEAS_W-1:0] mean_level;
    logic [MEAS_W-1:0] deviation;
    logic [MEAS_W-1:0] edge_count;
  } meas_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SQ_IDX_W-1:0] square;
    logic                occ;
    logic [BOARD_W-1:0]  prev;
    logic [BOARD_W-1:0]  cur;
  } result_t;

endpackage

// ===== hw/rtl/bsos_classify.sv =====
// ---------------------------------------------------------------------------
// bsos_classify
// Occupancy decision for one square from its edge, texture and mean figures
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bsos_classify (
  input  bsos_pkg::thr_cfg_t thr,
  input  bsos_pkg::meas_t    meas,
  input  logic               was_occ,
  output logic               now_occ
);
  import bsos_pkg::*;

  logic strong_hit;
  logic moderate;
  logic texture;
  logic clear_ok;
  logic dark;

  assign strong_hit = meas.edge_count > thr.strong_edge_limit;
  assign moderate   = meas.edge_count > thr.moderate_edge_limit;
  assign texture    = meas.deviation > thr.texture_dev_limit;
  assign clear_ok   = (meas.edge_count < thr.clear_edge_limit) &&
                      (meas.deviation < thr.flat_dev_limit);
  assign dark       = meas.mean_level < thr.dark_mean_limit;

  always_comb begin
    if (thr.calibrated) begin
      // hysteresis: occupied squares only clear on low edges and flat texture
      if (was_occ) begin
        now_occ = !clear_ok;
      end else begin
        now_occ = strong_hit || (moderate && texture);
      end
    end else begin
      now_occ = dark;
    end
  end

endmodule

// ===== hw/rtl/board_square_occupancy_stability.sv =====
// ---------------------------------------------------------------------------
// board_square_occupancy_stability
// Per-square occupancy with hysteresis, stability counting and board events
// ---------------------------------------------------------------------------
// One transaction per square carries its edge count, deviation and mean. The
// block takes one transaction per clock unless the output stalls or a refresh
// pass runs. Each passes an input register with the counter memory read, then
// the decision stage feeding an output register. A square whose occupancy
// flips gives a move result; the square SQUARES-1 closes the frame and may
// add a became-stable result (with the previous snapshot and the current
// board) or a became-unstable result. An input that yields two results holds
// the output for two transactions, so the input can stall then. Squares at or
// above SQUARES give no result and change nothing. Stability counters live in
// a SQUARES-deep memory with one read and one write port; a per-square stable
// flag keeps the frame-end check to a single AND. Writing stable_frames_needed
// starts a refresh pass that re-reads every counter through the memory read
// port to rebuild those flags; no transaction is accepted then.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module board_square_occupancy_stability #(
  parameter int SQUARES    = 64,
  parameter int COUNT_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // square_index[5:0], edge_count[17:6], deviation[29:18], mean_level[41:30]
  input  logic [bsos_pkg::IN_DATA_W-1:0]      in_tdata,
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // square[5:0], now_occupied[6], previous_board[70:7], current_board[134:71]
  output logic [bsos_pkg::OUT_DATA_W-1:0]     out_tdata,
  // event_kind[1:0]
  output logic [bsos_pkg::KIND_W-1:0]         out_tuser,
  output logic                                out_tlast,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [bsos_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [bsos_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import bsos_pkg::*;

  localparam int IDX_W    = (SQUARES > 1) ? $clog2(SQUARES) : 1;
  localparam int CMP_W    = (COUNT_BITS > NEED_W) ? COUNT_BITS : NEED_W;
  localparam int SQ_CMP_W = SQ_IDX_W + 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
  localparam logic [SQ_CMP_W-1:0]   SQ_LIMIT   = SQ_CMP_W'(SQUARES);
  localparam logic [SQ_IDX_W-1:0]   SQ_LAST    = SQ_IDX_W'(SQUARES - 1);
  localparam logic [IDX_W-1:0]      LAST_ADDR  = IDX_W'(SQUARES - 1);

  // configuration registers
  thr_cfg_t          thr_r;
  logic [NEED_W-1:0] need_r;

  // input stage
  logic                stg_vld_r;
  logic [SQ_IDX_W-1:0] stg_idx_r;
  meas_t               stg_meas_r;

  // counter memory, valid flags and forwarding of the latest write
  logic [COUNT_BITS-1:0] cnt_mem [SQUARES];
  logic [COUNT_BITS-1:0] rd_r;
  logic [SQUARES-1:0]    cnt_ok_r;
  logic                  fwd_vld_r;
  logic [IDX_W-1:0]      fwd_idx_r;
  logic [COUNT_BITS-1:0] fwd_cnt_r;

  // board state
  logic [SQUARES-1:0] occ_r;
  logic [SQUARES-1:0] stable_r;
  logic [SQUARES-1:0] snap_r;
  logic               brd_stable_r;

  // refresh pass after a stable_frames_needed write
  logic             sw_act_r;
  logic [IDX_W-1:0] sw_addr_r;
  logic             sw_ret_vld_r;
  logic [IDX_W-1:0] sw_ret_idx_r;
  logic             sw_busy;
  logic             sw_stab;

  // output buffer: head result plus one queued board result
  result_t out_r;
  result_t pend_r;
  logic    out_vld_r;
  logic    pend_vld_r;
  result_t out_nxt;
  result_t pend_nxt;
  logic    out_vld_nxt;
  logic    pend_vld_nxt;

  // decision stage signals
  logic                  in_acc;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic                  stg_in_rng;
  logic [IDX_W-1:0]      sq;
  logic                  was_occ;
  logic                  now_occ;
  logic                  changed;
  logic [COUNT_BITS-1:0] sat_lim;
  logic [COUNT_BITS-1:0] cnt_cur;
  logic [COUNT_BITS-1:0] cnt_new;
  logic                  stab_new;
  logic [SQUARES-1:0]    occ_nxt;
  logic [SQUARES-1:0]    stable_nxt;
  logic                  frame_end;
  logic                  all_st;
  logic                  brd_up;
  logic                  brd_dn;
  logic                  mv;
  logic                  has_first;
  logic                  has_second;
  logic                  room;
  logic                  stg_adv;
  logic                  upd;
  result_t               res_mv;
  result_t               res_brd;
  result_t               res_first;

  // --- configuration port --------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.calibrated          <= 1'b0;
      thr_r.strong_edge_limit   <= RST_STRONG;
      thr_r.moderate_edge_limit <= RST_MODERATE;
      thr_r.clear_edge_limit    <= RST_CLEAR;
      thr_r.texture_dev_limit   <= RST_TEXTURE;
      thr_r.flat_dev_limit      <= RST_FLAT;
      thr_r.dark_mean_limit     <= RST_DARK;
      need_r                    <= RST_NEED;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CALIBRATED: thr_r.calibrated          <= cfg_wdata[0];
        REG_NEED:       need_r                    <= cfg_wdata[NEED_W-1:0];
        REG_STRONG:     thr_r.strong_edge_limit   <= cfg_wdata[MEAS_W-1:0];
        REG_MODERATE:   thr_r.moderate_edge_limit <= cfg_wdata[MEAS_W-1:0];
        REG_CLEAR:      thr_r.clear_edge_limit    <= cfg_wdata[MEAS_W-1:0];
        REG_TEXTURE:    thr_r.texture_dev_limit   <= cfg_wdata[MEAS_W-1:0];
        REG_FLAT:       thr_r.flat_dev_limit      <= cfg_wdata[MEAS_W-1:0];
        REG_DARK:       thr_r.dark_mean_limit     <= cfg_wdata[MEAS_W-1:0];
        default: ;
      endcase
    end
  end

  // --- handshake -----------------------------------------------------------
  assign sw_busy   = sw_act_r || sw_ret_vld_r;
  assign room      = !out_vld_r || (out_tready && !pend_vld_r);
  assign stg_adv   = stg_vld_r && (!has_first || room);
  assign in_tready = !sw_busy && (!stg_vld_r || stg_adv);
  assign in_acc    = in_tvalid && in_tready;

  // --- input register --------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (in_acc) begin
      stg_vld_r <= 1'b1;
    end else if (stg_adv) begin
      stg_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_idx_r  <= in_tdata[SQ_IDX_W-1:0];
      stg_meas_r <= in_tdata[SQ_IDX_W +: 3*MEAS_W];
    end
  end

  // --- counter memory ------------------------------------------------------
  // the read port serves the incoming square, or the refresh pass
  assign rd_en   = in_acc || sw_act_r;
  assign rd_addr = sw_act_r ? sw_addr_r : in_tdata[IDX_W-1:0];
  assign upd     = stg_adv && stg_in_rng;

  always_ff @(posedge clk) begin
    if (upd) begin
      cnt_mem[sq] <= cnt_new;
    end
    if (rd_en) begin
      rd_r <= cnt_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_ok_r  <= '0;
      fwd_vld_r <= 1'b0;
    end else if (upd) begin
      cnt_ok_r[sq] <= 1'b1;
      fwd_vld_r    <= 1'b1;
    end
  end

  // the read issued in the same cycle as a write sees the old word
  always_ff @(posedge clk) begin
    if (upd) begin
      fwd_idx_r <= sq;
      fwd_cnt_r <= cnt_new;
    end
  end

  // --- decision stage --------------------------------------------------------
  assign stg_in_rng = {1'b0, stg_idx_r} < SQ_LIMIT;
  assign sq         = stg_idx_r[IDX_W-1:0];
  assign was_occ    = occ_r[sq];

  bsos_classify u_classify (
    .thr     (thr_r),
    .meas    (stg_meas_r),
    .was_occ (was_occ),
    .now_occ (now_occ)
  );

  // counters saturate at the smaller of the target and the counter range
  assign sat_lim = (CMP_W'(need_r) < CMP_W'(COUNT_MAX)) ?
                   COUNT_BITS'(CMP_W'(need_r)) : COUNT_MAX;

  always_comb begin
    if (fwd_vld_r && (fwd_idx_r == sq)) begin
      cnt_cur = fwd_cnt_r;
    end else if (cnt_ok_r[sq]) begin
      cnt_cur = rd_r;
    end else begin
      cnt_cur = '0;
    end
  end

  assign changed  = now_occ != was_occ;
  assign cnt_new  = changed ? '0 :
                    ((cnt_cur < sat_lim) ? cnt_cur + 1'b1 : cnt_cur);
  assign stab_new = CMP_W'(cnt_new) >= CMP_W'(need_r);

  always_comb begin
    occ_nxt    = occ_r;
    stable_nxt = stable_r;
    if (stg_in_rng) begin
      occ_nxt[sq]    = now_occ;
      stable_nxt[sq] = stab_new;
    end
  end

  assign frame_end  = stg_in_rng && (stg_idx_r == SQ_LAST);
  assign all_st     = &stable_nxt;
  assign brd_up     = frame_end && all_st && !brd_stable_r;
  assign brd_dn     = frame_end && !all_st && brd_stable_r;
  assign mv         = stg_in_rng && changed;
  assign has_first  = mv || brd_up || brd_dn;
  assign has_second = mv && (brd_up || brd_dn);

  always_comb begin
    res_mv        = '0;
    res_mv.kind   = EVT_MOVE;
    res_mv.square = stg_idx_r;
    res_mv.occ    = now_occ;

    res_brd = '0;
    if (brd_up) begin
      res_brd.kind = EVT_STABLE;
      res_brd.prev = BOARD_W'(snap_r);
      res_brd.cur  = BOARD_W'(occ_nxt);
    end else begin
      res_brd.kind = EVT_UNSTABLE;
    end

    res_first = mv ? res_mv : res_brd;
  end

  // --- board state -----------------------------------------------------------
  // refresh result for one square of the pass
  assign sw_stab = CMP_W'(cnt_ok_r[sw_ret_idx_r] ? rd_r : '0) >= CMP_W'(need_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r        <= '0;
      stable_r     <= '0;
      snap_r       <= '0;
      brd_stable_r <= 1'b0;
    end else begin
      if (upd) begin
        occ_r    <= occ_nxt;
        stable_r <= stable_nxt;
        if (brd_up) begin
          snap_r       <= occ_nxt;
          brd_stable_r <= 1'b1;
        end else if (brd_dn) begin
          brd_stable_r <= 1'b0;
        end
      end else if (sw_ret_vld_r) begin
        stable_r[sw_ret_idx_r] <= sw_stab;
      end
    end
  end

  // --- refresh pass ------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_act_r     <= 1'b0;
      sw_addr_r    <= '0;
      sw_ret_vld_r <= 1'b0;
      sw_ret_idx_r <= '0;
    end else begin
      sw_ret_vld_r <= sw_act_r;
      sw_ret_idx_r <= sw_addr_r;
      if (cfg_we && (cfg_addr == REG_NEED)) begin
        sw_act_r  <= 1'b1;
        sw_addr_r <= '0;
      end else if (sw_act_r) begin
        if (sw_addr_r == LAST_ADDR) begin
          sw_act_r <= 1'b0;
        end else begin
          sw_addr_r <= sw_addr_r + 1'b1;
        end
      end
    end
  end

  // --- output buffer -----------------------------------------------------------
  always_comb begin
    out_nxt      = out_r;
    pend_nxt     = pend_r;
    out_vld_nxt  = out_vld_r;
    pend_vld_nxt = pend_vld_r;
    if (out_vld_r && out_tready) begin
      if (pend_vld_r) begin
        out_nxt      = pend_r;
        pend_vld_nxt = 1'b0;
      end else begin
        out_vld_nxt = 1'b0;
      end
    end
    if (stg_adv && has_first) begin
      out_nxt      = res_first;
      out_vld_nxt  = 1'b1;
      pend_nxt     = res_brd;
      pend_vld_nxt = has_second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      pend_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_r.cur, out_r.prev, out_r.occ, out_r.square};
  assign out_tuser  = out_r.kind;
  // the head is the final result of its transaction unless a board result waits
  assign out_tlast  = !pend_vld_r;

  // --- checks ------------------------------------------------------------------
  `ASSERT_IMP(a_no_accept_in_refresh, sw_busy, !in_tready, "accept during refresh pass")
  `ASSERT_IMP(a_pend_behind_head, pend_vld_r, out_vld_r, "queued result without head")
  `ASSERT_IMP(a_pend_is_board, pend_vld_r, pend_r.kind != EVT_MOVE, "queued move result")
  `ASSERT_NXT(a_stable_snapshot, upd && brd_up, brd_stable_r && (snap_r == $past(occ_nxt)), "snapshot not taken")

endmodule
